// ----- sv/assert_macros.svh -----
// Assertion helpers, sampled on clk with reset masked.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/difl_pkg.sv -----
package difl_pkg;

  localparam int MAX_BLOCKS    = 256;
  localparam int MAX_RECORDS   = 4096;
  localparam int BLOCK_RECORDS = 64;

  localparam int BLK_AW = $clog2(MAX_BLOCKS);
  localparam int REC_AW = $clog2(MAX_RECORDS);

  typedef enum logic [1:0] {
    CMD_WR_BLOCK  = 2'd0,
    CMD_WR_RECORD = 2'd1,
    CMD_QUERY     = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NONE    = 2'd1,
    ST_CORRUPT = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] routing_rva;
    logic [63:0] base_rva;
    logic [31:0] start_line;
    logic [11:0] first_record;
    logic [6:0]  record_count;
  } blk_entry_t;

  typedef struct packed {
    logic [31:0] record_delta;
    logic [31:0] record_line;
  } rec_entry_t;

endpackage

// ----- sv/delta_index_floor_lookup.sv -----
// Two-level address-to-line index with floor lookup. Beats with tuser CMD_WR_BLOCK
// write one routing-table block entry, CMD_WR_RECORD writes one record
// (delta, line); both give no result. CMD_QUERY runs a binary search over
// the routing table (at most nine steps, one closing read), then decodes the
// selected block's records one at a time through a single shared 64-bit
// adder/comparator, and if nothing qualifies, the previous block too. The
// search takes at most ceil(log2(n+1)) steps for n blocks in use, and a
// finished query can wait on out_tready before the block goes idle.
// in_tready is low while a query runs; one finished result is held in the
// output register. No clearing pass: table contents are undefined until
// written. blocks_in_use is written on cfg, and cfg_ready is high only while
// the block is idle.
module delta_index_floor_lookup (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata, low bit up: slot[11:0], routing_rva[75:12], base_rva[139:76],
  // start_line[171:140], first_record[183:172], record_count[190:184],
  // record_delta[222:191], record_line[254:223], query_rva[318:255], pad
  input  logic [319:0] in_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: line[31:0]
  output logic [31:0]  out_tdata,
  // tuser: status[1:0]
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data
);
  import difl_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_CHK0, S_BS_RD, S_BS_CMP, S_SEL, S_BLK_RD, S_BLK,
    S_REC_RD, S_REC, S_END, S_DONE
  } state_t;

  // input field slices
  logic [11:0] f_slot;
  blk_entry_t  f_blk;
  rec_entry_t  f_rec;
  logic [63:0] f_query;
  assign f_slot             = in_tdata[11:0];
  assign f_blk.routing_rva  = in_tdata[75:12];
  assign f_blk.base_rva     = in_tdata[139:76];
  assign f_blk.start_line   = in_tdata[171:140];
  assign f_blk.first_record = in_tdata[183:172];
  assign f_blk.record_count = in_tdata[190:184];
  assign f_rec.record_delta = in_tdata[222:191];
  assign f_rec.record_line  = in_tdata[254:223];
  assign f_query            = in_tdata[318:255];

  state_t       state_r;
  logic [8:0]   biu_r;        // blocks_in_use
  logic [63:0]  q_r;
  logic [8:0]   lo_r, cnt_r;  // search window
  logic [7:0]   b_r;
  logic         second_r;
  logic [63:0]  addr_r;
  logic [31:0]  start_r, fl_r, ll_r;
  logic [11:0]  first_r;
  logic [6:0]   rcnt_r, i_r;
  logic         hf_r;
  logic [1:0]   res_st_r;
  logic [31:0]  res_line_r;
  logic         out_valid_r;
  logic [1:0]   out_st_r;
  logic [31:0]  out_line_r;

  logic         in_acc;
  cmd_t         cmd;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign cfg_ready = (state_r == S_IDLE);

  // memories
  logic             blk_we, rec_we;
  logic [BLK_AW-1:0] blk_raddr;
  blk_entry_t       blk_rd;
  rec_entry_t       rec_rd;
  logic [REC_AW-1:0] rec_raddr;
  logic [7:0]       step;
  logic [8:0]       probe;

  assign blk_we = in_acc && (cmd == CMD_WR_BLOCK) && (f_slot < 12'(MAX_BLOCKS));
  assign rec_we = in_acc && (cmd == CMD_WR_RECORD);
  assign step   = cnt_r[8:1];
  assign probe  = lo_r + {1'b0, step};

  always_comb begin
    unique case (state_r)
      S_BS_RD:  blk_raddr = probe[BLK_AW-1:0];
      S_BLK_RD: blk_raddr = b_r;
      default:  blk_raddr = '0;
    endcase
  end
  assign rec_raddr = first_r + {5'b0, i_r};

  difl_ram #(.WIDTH($bits(blk_entry_t)), .DEPTH(MAX_BLOCKS)) u_blk_ram (
    .clk(clk), .we(blk_we), .waddr(f_slot[BLK_AW-1:0]), .wdata(f_blk),
    .raddr(blk_raddr), .rdata(blk_rd)
  );

  difl_ram #(.WIDTH($bits(rec_entry_t)), .DEPTH(MAX_RECORDS)) u_rec_ram (
    .clk(clk), .we(rec_we), .waddr(f_slot[REC_AW-1:0]), .wdata(f_rec),
    .raddr(rec_raddr), .rdata(rec_rd)
  );

  // shared adder/comparator for record decode
  logic [63:0] sum;
  logic [31:0] rec_ln;
  assign sum    = addr_r + {32'b0, rec_rd.record_delta};
  assign rec_ln = (i_r == '0 && rec_rd.record_line == '0) ? start_r
                                                          : rec_rd.record_line;

  logic [12:0] span;
  assign span = {1'b0, blk_rd.first_record} + {6'b0, blk_rd.record_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      biu_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        biu_r <= (cfg_data > 9'(MAX_BLOCKS)) ? 9'(MAX_BLOCKS) : cfg_data;
      end
      // S_DONE reloads the output register itself
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && cmd == CMD_QUERY) begin
            q_r      <= f_query;
            second_r <= 1'b0;
            if (biu_r == '0) begin
              res_st_r   <= ST_NONE;
              res_line_r <= '0;
              state_r    <= S_DONE;
            end else begin
              state_r <= S_CHK0;
            end
          end
        end
        S_CHK0: begin
          lo_r  <= '0;
          cnt_r <= biu_r;
          if (q_r < blk_rd.routing_rva) begin
            res_st_r   <= ST_NONE;
            res_line_r <= '0;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_BS_RD;
          end
        end
        S_BS_RD: begin
          state_r <= (cnt_r == '0) ? S_SEL : S_BS_CMP;
        end
        S_BS_CMP: begin
          if (!(q_r < blk_rd.routing_rva)) begin
            lo_r  <= probe + 9'd1;
            cnt_r <= cnt_r - {1'b0, step} - 9'd1;
          end else begin
            cnt_r <= {1'b0, step};
          end
          state_r <= S_BS_RD;
        end
        S_SEL: begin
          if (lo_r == '0) begin
            res_st_r   <= ST_NONE;
            res_line_r <= '0;
            state_r    <= S_DONE;
          end else begin
            b_r     <= 8'(lo_r - 9'd1);
            state_r <= S_BLK_RD;
          end
        end
        S_BLK_RD: state_r <= S_BLK;
        S_BLK: begin
          addr_r  <= blk_rd.base_rva;
          start_r <= blk_rd.start_line;
          first_r <= blk_rd.first_record;
          rcnt_r  <= blk_rd.record_count;
          i_r     <= '0;
          hf_r    <= 1'b0;
          fl_r    <= '0;
          ll_r    <= '0;
          if (blk_rd.record_count > 7'(BLOCK_RECORDS) || span > 13'(MAX_RECORDS)) begin
            res_st_r   <= ST_CORRUPT;
            res_line_r <= '0;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_REC_RD;
          end
        end
        S_REC_RD: begin
          state_r <= (i_r == rcnt_r) ? S_END : S_REC;
        end
        S_REC: begin
          if (i_r != '0 && sum < addr_r) begin
            res_st_r   <= ST_CORRUPT;
            res_line_r <= '0;
            state_r    <= S_DONE;
          end else begin
            if (sum <= q_r) begin
              hf_r <= 1'b1;
              fl_r <= rec_ln;
            end
            ll_r    <= rec_ln;
            addr_r  <= sum;
            i_r     <= i_r + 7'd1;
            state_r <= S_REC_RD;
          end
        end
        S_END: begin
          state_r <= S_DONE;
          if (!second_r) begin
            if (hf_r) begin
              res_st_r   <= ST_FOUND;
              res_line_r <= fl_r;
            end else if (b_r == '0) begin
              res_st_r   <= ST_NONE;
              res_line_r <= '0;
            end else begin
              b_r      <= b_r - 8'd1;
              second_r <= 1'b1;
              state_r  <= S_BLK_RD;
            end
          end else if (rcnt_r == '0) begin
            res_st_r   <= ST_NONE;
            res_line_r <= '0;
          end else begin
            res_st_r   <= ST_FOUND;
            res_line_r <= ll_r;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_st_r    <= res_st_r;
            out_line_r  <= res_line_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_line_r;
  assign out_tuser  = out_st_r;

  `ASSERT_IMPL(a_line_zero, out_tvalid && out_tuser != ST_FOUND, out_tdata == '0, "line not zero")
  `ASSERT_NEXT(a_query_busy, in_acc && cmd == CMD_QUERY, !in_tready, "ready during query")
  `ASSERT_IMPL(a_lo_range, state_r == S_BS_CMP, probe < biu_r, "probe past table")

endmodule

// ----- sv/difl_ram.sv -----
module difl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
